### rtl/core/bba_pkg.sv
// Package for the bitmap block allocator: types, codes and default sizes.
// No dependencies; used by bba_front, bba_back and the top under rtl/core.
package bba_pkg;

   localparam int DefWordBits = 32;
   localparam int DefNumWords = 32;

   localparam int ActionWidth = 2;
   localparam int StatusWidth = 2;
   localparam int IndexWidth  = 10;
   localparam int AddrWidth   = 32;
   localparam int BsizeWidth  = 17;
   localparam int WordsWidth  = 6;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDatWidth = 32;

   typedef enum logic [ActionWidth-1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_OUTSIDE = 2'd2,
      ST_RSVD    = 2'd3
   } status_type;

   localparam logic [CsrIdxWidth-1:0] CSR_BLOCK_SIZE   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_WORDS_IN_USE = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_HEAP_BASE    = 2'd2;

   // Command handed from the front end to the back end
   typedef struct packed {
      action_type        action;
      logic [AddrWidth-1:0] address;
   } cmd_type;

endpackage

### rtl/core/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bba_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/bba_front.sv
// Front end: accepts items, holds them in a short command queue.
// Depends on bba_pkg.
module bba_front
   import bba_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [ActionWidth-1:0] req_action,
   input  logic [AddrWidth-1:0]   req_address,
   output logic                   cmd_valid,
   input  logic                   cmd_take,
   output cmd_type                cmd
);
   cmd_type    q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      wr_ptr_in = wr_ptr_ff ^ do_push;
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= '{action: action_type'(req_action), address: req_address};
      end
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) count_ff <= 2'd2;
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("cmd queue overflow");

   property p_pop_nonempty;
      @(posedge clock) disable iff (reset) (count_ff == 2'd0 && !do_push) |=> count_ff == 2'd0;
   endproperty
   a_pop_nonempty: assert property (p_pop_nonempty) else $error("cmd queue underflow");

   property p_count_step;
      @(posedge clock) disable iff (reset) (do_push && !do_pop) |=> count_ff == $past(count_ff) + 2'd1;
   endproperty
   a_count_step: assert property (p_count_step) else $error("cmd count mismatch");
endmodule

### rtl/core/bba_back.sv
// Back end: scans the bitmap RAM, computes addresses, divides on free,
// and posts one result per command. Depends on bba_pkg and bba_ram.
module bba_back
   import bba_pkg::*;
#(
   parameter int WordBits = DefWordBits,
   parameter int NumWords = DefNumWords
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_take,
   input  cmd_type                cmd,
   input  logic [BsizeWidth-1:0]  block_size,
   input  logic [WordsWidth-1:0]  words_in_use,
   input  logic [AddrWidth-1:0]   heap_base,
   output logic                   res_valid,
   input  logic                   res_take,
   output logic [StatusWidth-1:0] res_status,
   output logic [IndexWidth-1:0]  res_index,
   output logic [AddrWidth-1:0]   res_address
);
   localparam int WIdxW  = (NumWords > 1) ? $clog2(NumWords) : 1;
   localparam int BitW   = $clog2(WordBits);
   localparam int NW1    = $clog2(NumWords + 1);
   localparam int CntW   = (NW1 > WordsWidth) ? NW1 : WordsWidth;
   localparam int BlkW   = CntW + BitW;
   localparam int IdxW   = WIdxW + BitW;
   localparam int SelW   = (IdxW > 1) ? $clog2(IdxW) : 1;
   localparam int SpanW  = BlkW + BsizeWidth;
   localparam int QW     = 33;
   localparam int DivW   = 6;
   localparam logic [CntW-1:0] NumWordsC = CntW'(NumWords);

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_RD, S_CHK, S_MUL, S_DIV, S_FRD, S_FWAIT, S_FWR, S_OUT
   } state_type;

   state_type               state_ff;
   logic [WIdxW-1:0]        hint_ff;
   logic [WIdxW-1:0]        w_ff;
   logic [CntW-1:0]         n_ff;
   logic [CntW-1:0]         k_ff;
   logic [NumWords-1:0]     valid_ff;       // per-word valid, invalid reads zero
   logic [IdxW-1:0]         idx_ff;
   logic [BitW-1:0]         bit_ff;
   logic [QW-1:0]           rem_ff;
   logic [DivW-1:0]         dcnt_ff;
   logic [StatusWidth-1:0]  st_ff;
   logic [IndexWidth-1:0]   oidx_ff;
   logic [AddrWidth-1:0]    oaddr_ff;
   logic                    ovalid_ff;
   logic [WordBits-1:0]     word_ff;

   logic                    wr_en;
   logic [WIdxW-1:0]        wr_addr, rd_addr;
   logic [WordBits-1:0]     wr_data, rd_raw, rd_word;
   logic [BitW-1:0]         lowz;
   logic                    word_full;
   logic [CntW-1:0]         act_n;
   logic [SpanW-1:0]        span;
   logic [AddrWidth:0]      hi_bound, offs;
   logic [QW:0]             trial;

   bba_ram #(.Width(WordBits), .Depth(NumWords)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_raw)
   );

   assign rd_word   = valid_ff[w_ff] ? rd_raw : '0;
   assign word_full = &rd_word;
   assign act_n     = (CntW'(words_in_use) > NumWordsC) ? NumWordsC : CntW'(words_in_use);

   // Find lowest clear bit
   always_comb begin
      lowz = '0;
      for (int i = WordBits - 1; i >= 0; i--) begin
         if (!rd_word[i]) lowz = BitW'(i);
      end
   end

   assign span     = SpanW'({n_ff, {BitW{1'b0}}}) * SpanW'(block_size);
   assign hi_bound = (AddrWidth+1)'(heap_base) + (AddrWidth+1)'(span);
   assign offs     = {1'b0, cmd.address} - {1'b0, heap_base};
   assign trial    = {1'b0, rem_ff} - ((QW+1)'(block_size) << dcnt_ff[SelW-1:0]);

   assign cmd_take  = (state_ff == S_OUT) && !ovalid_ff;
   assign res_valid = ovalid_ff;
   assign res_status  = st_ff;
   assign res_index   = oidx_ff;
   assign res_address = oaddr_ff;

   always_comb begin
      rd_addr = w_ff;
      wr_en   = 1'b0;
      wr_addr = w_ff;
      wr_data = rd_word;
      if (state_ff == S_CHK && cmd.action == ACT_ALLOC && !word_full && k_ff < n_ff) begin
         wr_en   = 1'b1;
         wr_data = rd_word | (WordBits'(1) << lowz);
      end else if (state_ff == S_FWR) begin
         wr_en   = 1'b1;
         wr_data = word_ff & ~(WordBits'(1) << bit_ff);
      end
   end

   // Hold state, pointers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         hint_ff   <= '0;
         valid_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (res_take && ovalid_ff) ovalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               // Start only once the previous result has been read
               if (cmd_valid && !ovalid_ff) begin
                  n_ff  <= act_n;
                  k_ff  <= '0;
                  w_ff  <= (CntW'(hint_ff) < act_n) ? hint_ff : '0;
                  st_ff <= (cmd.action == ACT_ALLOC && act_n == '0) ? ST_FULL : ST_OK;
                  oidx_ff <= '0; oaddr_ff <= '0;
                  unique case (cmd.action)
                     ACT_ALLOC: state_ff <= (act_n == '0) ? S_OUT : S_RD;
                     ACT_FREE:  state_ff <= S_CHK;
                     ACT_CLEAR: state_ff <= S_CLR;
                     default:   state_ff <= S_OUT;
                  endcase
               end
            end
            S_CLR: begin
               valid_ff <= '0;
               state_ff <= S_OUT;
            end
            S_RD: state_ff <= (cmd.action == ACT_ALLOC) ? S_CHK : S_FWAIT;
            S_CHK: begin
               if (cmd.action == ACT_FREE) begin
                  // Containment check on the entry cycle
                  if (cmd.address < heap_base || hi_bound <= {1'b0, cmd.address}
                      || block_size == '0 || n_ff == '0) begin
                     st_ff    <= ST_OUTSIDE;
                     state_ff <= S_OUT;
                  end else begin
                     rem_ff   <= QW'(offs);
                     idx_ff   <= '0;
                     dcnt_ff  <= DivW'(IdxW - 1);
                     state_ff <= S_DIV;
                  end
               end else if (k_ff >= n_ff) begin
                  st_ff    <= ST_FULL;
                  state_ff <= S_OUT;
               end else if (!word_full) begin
                  valid_ff[w_ff] <= 1'b1;
                  hint_ff  <= w_ff;
                  idx_ff   <= {w_ff, lowz};
                  oidx_ff  <= IndexWidth'({w_ff, lowz});
                  state_ff <= S_MUL;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  w_ff     <= (CntW'(w_ff) + 1'b1 >= n_ff) ? '0 : w_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_MUL: begin
               oaddr_ff <= heap_base + AddrWidth'(AddrWidth'(idx_ff) * AddrWidth'(block_size));
               state_ff <= S_OUT;
            end
            S_DIV: begin
               // One quotient bit per cycle, restoring
               if (!trial[QW]) begin
                  rem_ff <= trial[QW-1:0];
                  idx_ff[dcnt_ff[SelW-1:0]] <= 1'b1;
               end
               if (dcnt_ff == '0) state_ff <= S_FRD;
               dcnt_ff <= dcnt_ff - 1'b1;
            end
            S_FRD: begin
               w_ff     <= idx_ff[IdxW-1:BitW];
               bit_ff   <= idx_ff[BitW-1:0];
               oidx_ff  <= IndexWidth'(idx_ff);
               state_ff <= S_RD;
            end
            S_FWAIT: begin
               word_ff  <= rd_word;
               state_ff <= S_FWR;
            end
            S_FWR: begin
               valid_ff[w_ff] <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!ovalid_ff) begin
                  ovalid_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   property p_take_once;
      @(posedge clock) disable iff (reset) cmd_take |=> !cmd_take;
   endproperty
   a_take_once: assert property (p_take_once) else $error("double command take");

   property p_hint_range;
      @(posedge clock) disable iff (reset) (state_ff == S_MUL) |-> CntW'(hint_ff) < n_ff;
   endproperty
   a_hint_range: assert property (p_hint_range) else $error("hint out of range");

   property p_full_status;
      @(posedge clock) disable iff (reset) (cmd_take && st_ff == ST_FULL) |-> oaddr_ff == '0;
   endproperty
   a_full_status: assert property (p_full_status) else $error("full result carries address");
endmodule

### rtl/core/bitmap_block_allocator_top.sv
// Channel   Handshake           Payload
// req       push / full         req_action, req_address
// rsp       empty / pop         rsp_status, rsp_block_index, rsp_block_address
// csr       csr_valid/csr_ready csr_index, csr_data
// Allocate finishes soonest when the hint word has room and takes longer for each full word
// skipped; a full 32-word pool reports full.
// Free runs the address through the one-bit-per-cycle divider; an address
// outside the pool, clear and the unused action skip the divider.
// Reset empties the bitmap at once through per-word valid bits.
// A two-entry command queue takes items while the back end works; the back end
// holds its next command until the one result register has been popped.
// Depends on bba_pkg, bba_front, bba_back.
module bitmap_block_allocator_top
   import bba_pkg::*;
#(
   parameter int WordBits = DefWordBits,
   parameter int NumWords = DefNumWords
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [ActionWidth-1:0] req_action,
   input  logic [AddrWidth-1:0]   req_address,
   output logic                   empty,
   input  logic                   pop,
   output logic [StatusWidth-1:0] rsp_status,
   output logic [IndexWidth-1:0]  rsp_block_index,
   output logic [AddrWidth-1:0]   rsp_block_address,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDatWidth-1:0] csr_data
);
   logic [BsizeWidth-1:0] block_size_ff;
   logic [WordsWidth-1:0] words_in_use_ff;
   logic [AddrWidth-1:0]  heap_base_ff;
   logic                  cmd_valid, cmd_take, res_valid;
   cmd_type               cmd;

   assign csr_ready = 1'b1;
   assign empty     = !res_valid;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff   <= BsizeWidth'(16);
         words_in_use_ff <= WordsWidth'(32);
         heap_base_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BLOCK_SIZE:   block_size_ff   <= csr_data[BsizeWidth-1:0];
            CSR_WORDS_IN_USE: words_in_use_ff <= csr_data[WordsWidth-1:0];
            CSR_HEAP_BASE:    heap_base_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   bba_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_action(req_action), .req_address(req_address),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
   );

   bba_back #(.WordBits(WordBits), .NumWords(NumWords)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd(cmd), .block_size(block_size_ff), .words_in_use(words_in_use_ff),
      .heap_base(heap_base_ff), .res_valid(res_valid), .res_take(pop),
      .res_status(rsp_status), .res_index(rsp_block_index),
      .res_address(rsp_block_address)
   );
endmodule

### test/tb.sv
// Testbench for bitmap_block_allocator_top: allocate, free and clear against a
// predictor of the bitmap, next-fit hint and address scaling. Depends on bba_pkg.
module tb
   import bba_pkg::*;
();

   localparam int WatchdogLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [ActionWidth-1:0] req_action = '0;
   logic [AddrWidth-1:0] req_address = '0;
   logic empty;
   logic pop = 1'b0;
   logic [StatusWidth-1:0] rsp_status;
   logic [IndexWidth-1:0] rsp_block_index;
   logic [AddrWidth-1:0] rsp_block_address;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrDatWidth-1:0] csr_data = '0;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [IndexWidth-1:0]  index;
      logic [AddrWidth-1:0]   addr;
   } alloc_result_type;

   // predictor state
   logic [31:0] pool_map [DefNumWords];
   int unsigned hint;
   logic [16:0] cfg_bsize;
   logic [5:0]  cfg_words;
   logic [31:0] cfg_base;

   alloc_result_type pending_results[$];
   int error_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   bit done = 1'b0;

   bitmap_block_allocator_top u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic alloc_result_type predict_alloc(input logic [ActionWidth-1:0] act,
                                                      input logic [31:0] addr);
      alloc_result_type r;
      int unsigned n, w, j, idx;
      longint unsigned span, blocks;
      r = '0;
      n = (cfg_words > DefNumWords) ? DefNumWords : cfg_words;
      case (act)
         ACT_ALLOC: begin
            r.status = ST_FULL;
            w = (hint < n) ? hint : 0;
            for (int k = 0; k < n; k++) begin
               if (pool_map[w] != 32'hFFFF_FFFF) begin
                  j = 0;
                  while (pool_map[w][j]) j++;
                  pool_map[w][j] = 1'b1;
                  hint = w;
                  idx = w * 32 + j;
                  r.status = ST_OK;
                  r.index = idx[IndexWidth-1:0];
                  r.addr = cfg_base + idx * cfg_bsize;
                  break;
               end
               w = (w + 1 >= n) ? 0 : w + 1;
            end
         end
         ACT_FREE: begin
            blocks = n * 32;
            span = blocks * cfg_bsize;
            if (addr < cfg_base || longint'(addr) >= longint'(cfg_base) + span
                || cfg_bsize == 0) begin
               r.status = ST_OUTSIDE;
            end else begin
               idx = (addr - cfg_base) / cfg_bsize;
               pool_map[idx / 32][idx % 32] = 1'b0;
               r.index = idx[IndexWidth-1:0];
            end
         end
         ACT_CLEAR: begin
            foreach (pool_map[i]) pool_map[i] = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // send one item and queue its expected result; push stays high for the next item
   task automatic send_item(input logic [ActionWidth-1:0] act, input logic [31:0] addr);
      while ($urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_action <= act;
      req_address <= addr;
      do @(posedge clock); while (full);
      pending_results.push_back(predict_alloc(act, addr));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   // csr_valid stays high for a following write; callers drop it
   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BLOCK_SIZE:   cfg_bsize = val[16:0];
         CSR_WORDS_IN_USE: cfg_words = val[5:0];
         CSR_HEAP_BASE:    cfg_base = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_pool(input logic [31:0] bsize, input logic [31:0] words,
                           input logic [31:0] base);
      wait_drained();
      write_reg(CSR_BLOCK_SIZE, bsize);
      write_reg(CSR_WORDS_IN_USE, words);
      write_reg(CSR_HEAP_BASE, base);
      csr_valid <= 1'b0;
   endtask

   // address of a random block, mostly inside the pool
   function automatic logic [31:0] pick_address();
      int unsigned n, idx;
      n = (cfg_words > DefNumWords) ? DefNumWords : cfg_words;
      idx = $urandom_range(n * 32 + 2);
      if ($urandom_range(9) == 0) return $urandom;
      return cfg_base + idx * cfg_bsize + $urandom_range(cfg_bsize > 0 ? cfg_bsize - 1 : 0);
   endfunction

   task automatic test_directed();
      set_pool(16, 1, 32'h1000);
      repeat (33) send_item(ACT_ALLOC, 0);
      send_item(ACT_FREE, 32'h1000);
      send_item(ACT_FREE, 32'h1000);
      send_item(ACT_FREE, 32'h0FFF);
      send_item(ACT_FREE, 32'h1200);
      send_item(ACT_FREE, 32'h11FF);
      send_item(ACT_ALLOC, 0);
      send_item(ACT_NONE, 32'hFFFF_FFFF);
      send_item(ACT_CLEAR, 0);
      set_pool(0, 0, 32'hFFFF_FFF0);
      send_item(ACT_ALLOC, 0);
      send_item(ACT_FREE, 32'hFFFF_FFF0);
      wait_drained();
      write_reg(CSR_WORDS_IN_USE, 63);
      csr_valid <= 1'b0;
      send_item(ACT_ALLOC, 0);
      send_item(ACT_FREE, 32'hFFFF_FFFF);
      set_pool(65536, 32, 32'hFFFF_FFFF);
      send_item(ACT_ALLOC, 0);
      send_item(ACT_FREE, 32'hFFFF_FFFF);
      set_pool(131071, 3, 32'h8000_0000);
      send_item(ACT_ALLOC, 0);
      send_item(ACT_FREE, 32'h8000_0000);
   endtask

   // alloc/free mix with random content, including out-of-pool frees and the unused action; clear now and then
   task automatic test_random(input int count, input int idle, input int stall);
      idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(19))
            0: send_item(ACT_CLEAR, $urandom);
            1: send_item(ACT_NONE, $urandom);
            2, 3, 4, 5, 6, 7: send_item(ACT_FREE, pick_address());
            default: send_item(ACT_ALLOC, $urandom);
         endcase
      end
   endtask

   task automatic test_pause();
      idle_pct = 0;
      stall_pct = 0;
      wait_drained();
      send_item(ACT_ALLOC, 0);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_status), 32'd0);
         end else begin
            alloc_result_type e;
            e = pending_results.pop_front();
            if (rsp_status !== e.status)
               report_mismatch("status", 32'(rsp_status), 32'(e.status));
            if (rsp_block_index !== e.index)
               report_mismatch("block_index", 32'(rsp_block_index), 32'(e.index));
            if (rsp_block_address !== e.addr)
               report_mismatch("block_address", rsp_block_address, e.addr);
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready) || done)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("bitmap_block_allocator_top test failed");
         $finish;
      end
   end

   initial begin
      foreach (pool_map[i]) pool_map[i] = '0;
      hint = 0;
      cfg_bsize = 16;
      cfg_words = 32;
      cfg_base = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      set_pool(16, 32, 0);
      test_random(150, 0, 0);
      set_pool(1, 2, 32'h10);
      test_random(150, 77, 0);
      test_pause();
      set_pool($urandom_range(131071), $urandom_range(63), $urandom);
      test_random(150, 0, 77);
      set_pool(65536, 1, 32'hFFFF_0000);
      test_random(150, 30, 30);
      idle_pct = 0;
      stall_pct = 0;
      wait_drained();
      done = 1'b1;
      if (error_count == 0 && pending_results.size() == 0)
         $display("bitmap_block_allocator_top test passed");
      else
         $display("bitmap_block_allocator_top test failed");
      $finish;
   end
endmodule
